@@ rtl/core/spn_pkg.sv @@
// spn_pkg: shared types, opcode and segment codes, saturating arithmetic
// for the SVG path command normalizer. No dependencies.
package spn_pkg;

    localparam int COORD_BITS = 32;
    localparam int OUTQ_DEPTH = 4;
    localparam int OUTQ_AW    = $clog2(OUTQ_DEPTH);

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic [3:0] op_t;
    typedef logic [2:0] kind_t;

    localparam coord_t COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
    localparam coord_t COORD_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};

    // Command codes; OP_NONE doubles as the "repeat" code on the input
    localparam op_t OP_NONE  = 4'd0;
    localparam op_t OP_M     = 4'd1;
    localparam op_t OP_L     = 4'd2;
    localparam op_t OP_H     = 4'd3;
    localparam op_t OP_V     = 4'd4;
    localparam op_t OP_C     = 4'd5;
    localparam op_t OP_S     = 4'd6;
    localparam op_t OP_Q     = 4'd7;
    localparam op_t OP_T     = 4'd8;
    localparam op_t OP_Z     = 4'd9;
    localparam op_t OP_TILDE = 4'd10;

    localparam kind_t KIND_MOVE  = 3'd0;
    localparam kind_t KIND_LINE  = 3'd1;
    localparam kind_t KIND_QUAD  = 3'd2;
    localparam kind_t KIND_CUBIC = 3'd3;
    localparam kind_t KIND_CLOSE = 3'd4;

    typedef struct packed {
        op_t    command;
        logic   is_relative;
        coord_t ax;
        coord_t ay;
        coord_t bx;
        coord_t by;
        coord_t cx;
        coord_t cy;
    } cmd_word_t;

    typedef struct packed {
        kind_t  segment_kind;
        coord_t p1x;
        coord_t p1y;
        coord_t p2x;
        coord_t p2y;
        coord_t p3x;
        coord_t p3y;
        logic   error_flag;
        logic   last_of_run;
    } seg_word_t;

    typedef struct packed {
        logic push;
        logic pair;
    } push_ctl_t;

    function automatic coord_t sat_add(coord_t a, coord_t b);
        logic signed [COORD_BITS:0] s;
        s = {a[COORD_BITS-1], a} + {b[COORD_BITS-1], b};
        if (s[COORD_BITS] != s[COORD_BITS-1])
            return s[COORD_BITS] ? COORD_MIN : COORD_MAX;
        return s[COORD_BITS-1:0];
    endfunction

    function automatic coord_t sat_sub(coord_t a, coord_t b);
        logic signed [COORD_BITS:0] s;
        s = {a[COORD_BITS-1], a} - {b[COORD_BITS-1], b};
        if (s[COORD_BITS] != s[COORD_BITS-1])
            return s[COORD_BITS] ? COORD_MIN : COORD_MAX;
        return s[COORD_BITS-1:0];
    endfunction

endpackage

@@ rtl/core/spn_if.sv @@
// spn_if: valid/ready channel interfaces for command words and segment words.
// Depends on spn_pkg.
interface spn_cmd_if;
    import spn_pkg::*;
    logic      valid;
    logic      ready;
    cmd_word_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface spn_seg_if;
    import spn_pkg::*;
    logic      valid;
    logic      ready;
    seg_word_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/core/spn_core.sv @@
// spn_core: input register, path state and the single-pass command decode.
// Depends on spn_pkg and spn_if.
module spn_core (
    input  logic                clk,
    input  logic                rst_n,
    spn_cmd_if.sink             cmd,
    input  logic                room,
    output spn_pkg::push_ctl_t  push_ctl,
    output spn_pkg::seg_word_t  res0,
    output spn_pkg::seg_word_t  res1
);
    import spn_pkg::*;

    logic      in_valid_reg, in_valid_next;
    cmd_word_t in_word_reg;
    logic      fire;

    coord_t cur_x_reg, cur_y_reg, start_x_reg, start_y_reg, ctl_x_reg, ctl_y_reg;
    coord_t cur_x_next, cur_y_next, start_x_next, start_y_next, ctl_x_next, ctl_y_next;
    op_t    active_op_reg, active_op_next, prior_op_reg, prior_op_next;
    logic   rel_mode_reg, rel_mode_next;

    op_t    op;
    logic   rel, err, offs, pair;
    coord_t vax, vay, vbx, vby, vcx, vcy;
    coord_t rx, ry, hx, vy, tx, ty;

    assign fire      = in_valid_reg && room;
    assign cmd.ready = !in_valid_reg || room;

    always_comb
    begin
        if (cmd.valid && cmd.ready)
            in_valid_next = 1'b1;
        else if (fire)
            in_valid_next = 1'b0;
        else
            in_valid_next = in_valid_reg;
    end

    always_comb
    begin
        if (in_word_reg.command == OP_NONE)
        begin
            op  = active_op_reg;
            rel = rel_mode_reg;
        end
        else
        begin
            op  = in_word_reg.command;
            rel = in_word_reg.is_relative;
        end
        err  = (op == OP_NONE) || (op > OP_TILDE);
        offs = rel && (op != OP_TILDE) && (op != OP_H) && (op != OP_V);

        vax = offs ? sat_add(in_word_reg.ax, cur_x_reg) : in_word_reg.ax;
        vay = offs ? sat_add(in_word_reg.ay, cur_y_reg) : in_word_reg.ay;
        vbx = offs ? sat_add(in_word_reg.bx, cur_x_reg) : in_word_reg.bx;
        vby = offs ? sat_add(in_word_reg.by, cur_y_reg) : in_word_reg.by;
        vcx = offs ? sat_add(in_word_reg.cx, cur_x_reg) : in_word_reg.cx;
        vcy = offs ? sat_add(in_word_reg.cy, cur_y_reg) : in_word_reg.cy;

        // reflected control point for smooth curves
        rx = sat_add(cur_x_reg, sat_sub(cur_x_reg, ctl_x_reg));
        ry = sat_add(cur_y_reg, sat_sub(cur_y_reg, ctl_y_reg));
        hx = rel ? sat_add(cur_x_reg, in_word_reg.ax) : in_word_reg.ax;
        vy = rel ? sat_add(cur_y_reg, in_word_reg.ax) : in_word_reg.ax;
        tx = cur_x_reg;
        ty = cur_y_reg;

        res0 = '0;
        res0.last_of_run = 1'b1;
        res1 = '0;
        res1.last_of_run = 1'b1;
        pair = 1'b0;

        cur_x_next     = cur_x_reg;
        cur_y_next     = cur_y_reg;
        start_x_next   = start_x_reg;
        start_y_next   = start_y_reg;
        ctl_x_next     = ctl_x_reg;
        ctl_y_next     = ctl_y_reg;
        active_op_next = active_op_reg;
        prior_op_next  = prior_op_reg;
        rel_mode_next  = rel_mode_reg;

        if (err)
        begin
            res0.segment_kind = KIND_MOVE;
            res0.error_flag   = 1'b1;
        end
        else
        begin
            unique case (op)
                OP_M:
                begin
                    res0.segment_kind = KIND_MOVE;
                    res0.p1x = vax;
                    res0.p1y = vay;
                    cur_x_next   = vax;
                    cur_y_next   = vay;
                    start_x_next = vax;
                    start_y_next = vay;
                end
                OP_L:
                begin
                    res0.segment_kind = KIND_LINE;
                    res0.p1x = vax;
                    res0.p1y = vay;
                    cur_x_next = vax;
                    cur_y_next = vay;
                end
                OP_H:
                begin
                    res0.segment_kind = KIND_LINE;
                    res0.p1x = hx;
                    res0.p1y = cur_y_reg;
                    cur_x_next = hx;
                end
                OP_V:
                begin
                    res0.segment_kind = KIND_LINE;
                    res0.p1x = cur_x_reg;
                    res0.p1y = vy;
                    cur_y_next = vy;
                end
                OP_C:
                begin
                    res0.segment_kind = KIND_CUBIC;
                    res0.p1x = vax;
                    res0.p1y = vay;
                    res0.p2x = vbx;
                    res0.p2y = vby;
                    res0.p3x = vcx;
                    res0.p3y = vcy;
                    ctl_x_next = vbx;
                    ctl_y_next = vby;
                    cur_x_next = vcx;
                    cur_y_next = vcy;
                end
                OP_S:
                begin
                    if (prior_op_reg == OP_C || prior_op_reg == OP_S)
                    begin
                        tx = rx;
                        ty = ry;
                    end
                    res0.segment_kind = KIND_CUBIC;
                    res0.p1x = tx;
                    res0.p1y = ty;
                    res0.p2x = vax;
                    res0.p2y = vay;
                    res0.p3x = vbx;
                    res0.p3y = vby;
                    ctl_x_next = vax;
                    ctl_y_next = vay;
                    cur_x_next = vbx;
                    cur_y_next = vby;
                end
                OP_Q:
                begin
                    res0.segment_kind = KIND_QUAD;
                    res0.p1x = vax;
                    res0.p1y = vay;
                    res0.p2x = vbx;
                    res0.p2y = vby;
                    ctl_x_next = vax;
                    ctl_y_next = vay;
                    cur_x_next = vbx;
                    cur_y_next = vby;
                end
                OP_T:
                begin
                    if (prior_op_reg == OP_Q || prior_op_reg == OP_T)
                    begin
                        tx = rx;
                        ty = ry;
                    end
                    res0.segment_kind = KIND_QUAD;
                    res0.p1x = tx;
                    res0.p1y = ty;
                    res0.p2x = vax;
                    res0.p2y = vay;
                    ctl_x_next = tx;
                    ctl_y_next = ty;
                    cur_x_next = vax;
                    cur_y_next = vay;
                end
                OP_Z:
                begin
                    res0.segment_kind = KIND_CLOSE;
                    res0.p1x = start_x_reg;
                    res0.p1y = start_y_reg;
                    cur_x_next = start_x_reg;
                    cur_y_next = start_y_reg;
                end
                OP_TILDE:
                begin
                    // move then line, both absolute; geometry state untouched
                    res0.segment_kind = KIND_MOVE;
                    res0.p1x = in_word_reg.ax;
                    res0.p1y = in_word_reg.ay;
                    res0.last_of_run = 1'b0;
                    res1.segment_kind = KIND_LINE;
                    res1.p1x = in_word_reg.bx;
                    res1.p1y = in_word_reg.by;
                    pair = 1'b1;
                end
                default:
                begin
                    pair = 1'b0;
                end
            endcase

            rel_mode_next = rel;
            if (op == OP_M)
                active_op_next = OP_L;
            else if (op == OP_Z)
                active_op_next = OP_NONE;
            else
                active_op_next = op;
            prior_op_next = (op == OP_Z) ? OP_NONE : op;
        end
    end

    assign push_ctl.push = fire;
    assign push_ctl.pair = pair;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            cur_x_reg     <= '0;
            cur_y_reg     <= '0;
            start_x_reg   <= '0;
            start_y_reg   <= '0;
            ctl_x_reg     <= '0;
            ctl_y_reg     <= '0;
            active_op_reg <= OP_NONE;
            prior_op_reg  <= OP_NONE;
            rel_mode_reg  <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
            if (fire)
            begin
                cur_x_reg     <= cur_x_next;
                cur_y_reg     <= cur_y_next;
                start_x_reg   <= start_x_next;
                start_y_reg   <= start_y_next;
                ctl_x_reg     <= ctl_x_next;
                ctl_y_reg     <= ctl_y_next;
                active_op_reg <= active_op_next;
                prior_op_reg  <= prior_op_next;
                rel_mode_reg  <= rel_mode_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.valid && cmd.ready)
            in_word_reg <= cmd.data;
    end

    a_err_keeps_state: assert property (@(posedge clk) disable iff (!rst_n)
        fire && err |=> $stable(cur_x_reg) && $stable(active_op_reg)
                        && $stable(prior_op_reg) && $stable(rel_mode_reg))
        else $error("error word changed path state");

    a_tilde_pair: assert property (@(posedge clk) disable iff (!rst_n)
        fire && !err && op == OP_TILDE |-> push_ctl.pair && !res0.last_of_run)
        else $error("tilde word did not produce a move/line pair");

    a_held_word: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !room |=> in_valid_reg && $stable(in_word_reg))
        else $error("stalled input word lost or changed");

endmodule

@@ rtl/core/spn_outq.sv @@
// spn_outq: small result queue taking one or two segment words per cycle.
// Depends on spn_pkg and spn_if.
module spn_outq (
    input  logic                clk,
    input  logic                rst_n,
    input  spn_pkg::push_ctl_t  push_ctl,
    input  spn_pkg::seg_word_t  wr0,
    input  spn_pkg::seg_word_t  wr1,
    output logic                room,
    spn_seg_if.source           seg
);
    import spn_pkg::*;

    seg_word_t              mem_reg [OUTQ_DEPTH];
    logic [OUTQ_AW-1:0]     wr_ptr_reg, wr_ptr_next, rd_ptr_reg, rd_ptr_next;
    logic [OUTQ_AW:0]       count_reg, count_next;
    logic                   pop;
    logic [OUTQ_AW-1:0]     wr_ptr_plus1;

    // room for a full pair, from registered count only
    assign room      = count_reg <= (OUTQ_AW+1)'(OUTQ_DEPTH - 2);
    assign seg.valid = count_reg != '0;
    assign seg.data  = mem_reg[rd_ptr_reg];
    assign pop       = seg.valid && seg.ready;
    assign wr_ptr_plus1 = wr_ptr_reg + 1'b1;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        if (push_ctl.push)
            wr_ptr_next = push_ctl.pair ? wr_ptr_reg + (OUTQ_AW)'(2) : wr_ptr_plus1;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg
                    + (OUTQ_AW+1)'(push_ctl.push)
                    + (OUTQ_AW+1)'(push_ctl.push && push_ctl.pair)
                    - (OUTQ_AW+1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_ctl.push)
        begin
            mem_reg[wr_ptr_reg] <= wr0;
            if (push_ctl.pair)
                mem_reg[wr_ptr_plus1] <= wr1;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= (OUTQ_AW+1)'(OUTQ_DEPTH))
        else $error("result queue overflow");

    a_push_visible: assert property (@(posedge clk) disable iff (!rst_n)
        push_ctl.push |=> count_reg != '0)
        else $error("pushed word not visible");

    a_push_has_room: assert property (@(posedge clk) disable iff (!rst_n)
        push_ctl.push |-> room)
        else $error("push without room");

endmodule

@@ rtl/core/svg_path_command_normalizer_top.sv @@
// svg_path_command_normalizer_top: SVG path command to absolute segment unit.
// Depends on spn_pkg, spn_if, spn_core, spn_outq.
//
//  Channel | Dir | Payload     | Meaning
//  --------+-----+-------------+----------------------------------------------
//  cmd     | in  | cmd_word_t  | tokenized path command with up to 3 points
//  seg     | out | seg_word_t  | absolute move/line/quad/cubic/close segment
//
// One command word per cycle while the queue has room: the word lands in an
// input register, is decoded against the path state in one pass and its
// segments enter a 4-deep queue. A tilde word yields two segment words,
// both written into the queue together. The first segment word passes the
// input register and then the queue, which makes it valid on seg.
// rst_n clears the path state to origin, no active or prior command.
// Output stalls back up into the queue; cmd.ready drops once fewer than two
// queue slots are free and an input word is held.
module svg_path_command_normalizer_top (
    input  logic      clk,
    input  logic      rst_n,
    spn_cmd_if.sink   cmd,
    spn_seg_if.source seg
);
    import spn_pkg::*;

    push_ctl_t push_ctl;
    seg_word_t res0;
    seg_word_t res1;
    logic      room;

    // decode stage: holds the current point, subpath start, control point
    spn_core u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .room     (room),
        .push_ctl (push_ctl),
        .res0     (res0),
        .res1     (res1)
    );

    // result queue: decouples the sink from the decode stage
    spn_outq u_outq (
        .clk      (clk),
        .rst_n    (rst_n),
        .push_ctl (push_ctl),
        .wr0      (res0),
        .wr1      (res1),
        .room     (room),
        .seg      (seg)
    );

endmodule

@@ sim/tb_svg_path_command_normalizer_top.sv @@
// Testbench for svg_path_command_normalizer_top: directed table plus random path streams,
// every segment word checked against an in-bench path-state predictor or a pinned row.
// Depends on spn_pkg, spn_if and the RTL top with its submodules.
`timescale 1ns / 100ps

module tb_svg_path_command_normalizer_top;
    import spn_pkg::*;

    localparam int RANDOM_WORDS = 2000;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int TAIL_CYCLES  = 8;

    // One directed stimulus row; pinned rows carry a hand-read first segment.
    typedef struct {
        cmd_word_t word;
        bit        pinned;
        seg_word_t pin;
    } stim_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    // Driven copies of the DUT inputs, known from time zero.
    logic      word_valid = 1'b0;
    cmd_word_t word_data = '0;
    bit        word_pinned = 1'b0;
    seg_word_t word_pin = '0;
    logic      sink_ready = 1'b0;
    bit        calm = 1'b0;

    spn_cmd_if cmd_ch ();
    spn_seg_if seg_ch ();

    assign cmd_ch.valid = word_valid;
    assign cmd_ch.data  = word_data;
    assign seg_ch.ready = sink_ready;

    svg_path_command_normalizer_top dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch.sink),
        .seg   (seg_ch.source)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // Path-state predictor: mirrors the block's registered path state.
    // ------------------------------------------------------------------
    coord_t pen_x = '0, pen_y = '0;   // current point
    coord_t sub_x = '0, sub_y = '0;   // subpath start
    coord_t ctl_x = '0, ctl_y = '0;   // last curve control point
    op_t    live_op = OP_NONE;        // command a bare operand group repeats
    op_t    last_op = OP_NONE;        // command executed last, for S/T reflection
    logic   live_rel = 1'b0;

    seg_word_t segment_expect[$];
    stim_row_t stim_table[$];

    int mismatches = 0;
    int words_in = 0;
    int segs_checked = 0;
    int error_segs = 0;
    int close_segs = 0;
    int tilde_pairs = 0;
    int cycle_count = 0;

    // Clamp a wide sum into the signed coordinate range.
    function automatic coord_t sat_sum(longint s);
        if (s > longint'(COORD_MAX))
            return COORD_MAX;
        if (s < longint'(COORD_MIN))
            return COORD_MIN;
        return coord_t'(s);
    endfunction

    // Reflect the control point c about p, each step clamped.
    function automatic coord_t mirror(coord_t p, coord_t c);
        return sat_sum(longint'(p) + longint'(sat_sum(longint'(p) - longint'(c))));
    endfunction

    task automatic predict_segments(input cmd_word_t w);
        op_t       op;
        op_t       follow_op;
        logic      rel;
        coord_t    v[6];
        coord_t    fx, fy;
        logic      refl;
        seg_word_t s, s2;

        if (w.command == OP_NONE)
        begin
            op  = live_op;
            rel = live_rel;
        end
        else
        begin
            op  = w.command;
            rel = w.is_relative;
        end
        s  = '0;
        s2 = '0;

        // Unknown code or a repeat with nothing to repeat: error word, state held.
        if (op == OP_NONE || op > OP_TILDE)
        begin
            s.error_flag  = 1'b1;
            s.last_of_run = 1'b1;
            segment_expect.push_back(s);
            return;
        end

        v[0] = w.ax; v[1] = w.ay;
        v[2] = w.bx; v[3] = w.by;
        v[4] = w.cx; v[5] = w.cy;
        // Offset every pair by the pre-command pen; H and V handle this themselves, tilde ignores it.
        if (rel && op != OP_TILDE && op != OP_H && op != OP_V)
        begin
            for (int i = 0; i < 6; i += 2)
            begin
                v[i]   = sat_sum(longint'(v[i]) + longint'(pen_x));
                v[i+1] = sat_sum(longint'(v[i+1]) + longint'(pen_y));
            end
        end
        follow_op = op;

        case (op)
            OP_M:
            begin
                s.segment_kind = KIND_MOVE;
                s.p1x = v[0];
                s.p1y = v[1];
                pen_x = v[0];
                pen_y = v[1];
                sub_x = v[0];
                sub_y = v[1];
                follow_op = OP_L;
            end
            OP_L:
            begin
                s.segment_kind = KIND_LINE;
                s.p1x = v[0];
                s.p1y = v[1];
                pen_x = v[0];
                pen_y = v[1];
            end
            OP_H:
            begin
                fx = rel ? sat_sum(longint'(pen_x) + longint'(v[0])) : v[0];
                s.segment_kind = KIND_LINE;
                s.p1x = fx;
                s.p1y = pen_y;
                pen_x = fx;
            end
            OP_V:
            begin
                fy = rel ? sat_sum(longint'(pen_y) + longint'(v[0])) : v[0];
                s.segment_kind = KIND_LINE;
                s.p1x = pen_x;
                s.p1y = fy;
                pen_y = fy;
            end
            OP_C, OP_S:
            begin
                s.segment_kind = KIND_CUBIC;
                if (op == OP_C)
                begin
                    s.p1x = v[0]; s.p1y = v[1];
                    s.p2x = v[2]; s.p2y = v[3];
                    s.p3x = v[4]; s.p3y = v[5];
                end
                else
                begin
                    refl  = (last_op == OP_C || last_op == OP_S);
                    s.p1x = refl ? mirror(pen_x, ctl_x) : pen_x;
                    s.p1y = refl ? mirror(pen_y, ctl_y) : pen_y;
                    s.p2x = v[0]; s.p2y = v[1];
                    s.p3x = v[2]; s.p3y = v[3];
                end
                ctl_x = s.p2x;
                ctl_y = s.p2y;
                pen_x = s.p3x;
                pen_y = s.p3y;
            end
            OP_Q, OP_T:
            begin
                s.segment_kind = KIND_QUAD;
                if (op == OP_Q)
                begin
                    s.p1x = v[0]; s.p1y = v[1];
                    s.p2x = v[2]; s.p2y = v[3];
                end
                else
                begin
                    refl  = (last_op == OP_Q || last_op == OP_T);
                    s.p1x = refl ? mirror(pen_x, ctl_x) : pen_x;
                    s.p1y = refl ? mirror(pen_y, ctl_y) : pen_y;
                    s.p2x = v[0]; s.p2y = v[1];
                end
                ctl_x = s.p1x;
                ctl_y = s.p1y;
                pen_x = s.p2x;
                pen_y = s.p2y;
            end
            OP_Z:
            begin
                s.segment_kind = KIND_CLOSE;
                s.p1x = sub_x;
                s.p1y = sub_y;
                pen_x = sub_x;
                pen_y = sub_y;
                follow_op = OP_NONE;
            end
            default:
            begin
                // Tilde: absolute move then line, pen, subpath start and control point untouched.
                s.segment_kind  = KIND_MOVE;
                s.p1x = w.ax;
                s.p1y = w.ay;
                s2.segment_kind = KIND_LINE;
                s2.p1x = w.bx;
                s2.p1y = w.by;
            end
        endcase

        if (op == OP_TILDE)
        begin
            s2.last_of_run = 1'b1;
            segment_expect.push_back(s);
            segment_expect.push_back(s2);
        end
        else
        begin
            s.last_of_run = 1'b1;
            segment_expect.push_back(s);
        end
        live_rel = rel;
        live_op  = follow_op;
        last_op  = (op == OP_Z) ? OP_NONE : op;
    endtask

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------
    function automatic void check_field(string field, logic [31:0] want, logic [31:0] got);
        if (got !== want)
        begin
            mismatches++;
            $display("%0t ns: %s mismatch, expected %h, actual %h",
                     $time, field, want, got);
        end
    endfunction

    // Monitor both channels at the edge; inputs first so a word's segments
    // are queued before anything that could pop them.
    always @(posedge clk)
    begin
        int        base;
        seg_word_t want;
        seg_word_t got;

        if (rst_n)
        begin
            if (cmd_ch.valid && cmd_ch.ready)
            begin
                base = segment_expect.size();
                predict_segments(cmd_ch.data);
                // Hand-read rows override the predictor's first segment.
                if (word_pinned)
                    segment_expect[base] = word_pin;
                if (segment_expect.size() - base == 2)
                    tilde_pairs++;
                words_in++;
            end
            if (seg_ch.valid && seg_ch.ready)
            begin
                got = seg_ch.data;
                if (segment_expect.size() == 0)
                begin
                    mismatches++;
                    $display("%0t ns: unexpected segment word, expected none, actual %h",
                             $time, got);
                end
                else
                begin
                    want = segment_expect.pop_front();
                    check_field("segment_kind", want.segment_kind, got.segment_kind);
                    check_field("p1x", want.p1x, got.p1x);
                    check_field("p1y", want.p1y, got.p1y);
                    check_field("p2x", want.p2x, got.p2x);
                    check_field("p2y", want.p2y, got.p2y);
                    check_field("p3x", want.p3x, got.p3x);
                    check_field("p3y", want.p3y, got.p3y);
                    check_field("error_flag", want.error_flag, got.error_flag);
                    check_field("last_of_run", want.last_of_run, got.last_of_run);
                    segs_checked++;
                    if (want.error_flag)
                        error_segs++;
                    if (want.segment_kind == KIND_CLOSE)
                        close_segs++;
                end
            end
        end
    end

    // Segment sink: drop ready in about one cycle in five unless calm.
    always @(posedge clk)
        sink_ready <= calm || ($urandom_range(0, 99) >= 20);

    // Watchdog: end the run if the block hangs.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("tb_svg_path_command_normalizer_top: errors");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic cmd_word_t make_word(op_t op, logic rel, coord_t ax, coord_t ay,
                                            coord_t bx = '0, coord_t by = '0,
                                            coord_t cx = '0, coord_t cy = '0);
        cmd_word_t w;
        w.command     = op;
        w.is_relative = rel;
        w.ax = ax; w.ay = ay;
        w.bx = bx; w.by = by;
        w.cx = cx; w.cy = cy;
        return w;
    endfunction

    function automatic seg_word_t point_seg(kind_t kind, coord_t x, coord_t y);
        seg_word_t s;
        s = '0;
        s.segment_kind = kind;
        s.p1x = x;
        s.p1y = y;
        s.last_of_run = 1'b1;
        return s;
    endfunction

    function automatic seg_word_t error_seg();
        seg_word_t s;
        s = '0;
        s.segment_kind = KIND_MOVE;
        s.error_flag   = 1'b1;
        s.last_of_run  = 1'b1;
        return s;
    endfunction

    function automatic void add_row(cmd_word_t w, bit pinned = 1'b0, seg_word_t pin = '0);
        stim_row_t r;
        r.word   = w;
        r.pinned = pinned;
        r.pin    = pin;
        stim_table.push_back(r);
    endfunction

    // Mix of small offsets, full-range noise, exact extremes and near-bound values.
    function automatic coord_t pick_coord();
        int k;
        k = $urandom_range(0, 99);
        if (k < 45)
            return coord_t'(int'($urandom_range(0, 32'h001F_FFFF)) - 32'h0010_0000);
        if (k < 65)
            return coord_t'($urandom);
        if (k < 80)
        begin
            case ($urandom_range(0, 4))
                0: return COORD_MAX;
                1: return COORD_MIN;
                2: return '0;
                3: return '1;
                default: return coord_t'(1);
            endcase
        end
        if (k < 90)
            return COORD_MAX - coord_t'($urandom_range(0, 255));
        return COORD_MIN + coord_t'($urandom_range(0, 255));
    endfunction

    // Present one word and hold it until accepted; maybe idle first unless calm.
    // Must be entered at a rising edge.
    task automatic send_word(cmd_word_t w, bit pinned, seg_word_t pin);
        if (!calm && $urandom_range(0, 99) < 20)
        begin
            word_valid <= 1'b0;
            @(posedge clk);
        end
        word_valid  <= 1'b1;
        word_data   <= w;
        word_pinned <= pinned;
        word_pin    <= pin;
        do
            @(posedge clk);
        while (!(cmd_ch.valid && cmd_ch.ready));
    endtask

    // Stop sending and wait until every queued segment has come out.
    task automatic drain_segments();
        word_valid <= 1'b0;
        do
            @(posedge clk);
        while (segment_expect.size() != 0);
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        cmd_word_t w;
        int        pick;
        bit        after_close;

        // Directed table. Pinned rows are the hand-checkable ones: error words,
        // moves and a line to the origin, and results pinned at the coordinate bounds.
        add_row(make_word(OP_NONE, 1'b0, 32'h1234, 32'h5678), 1'b1, error_seg());
        add_row(make_word(op_t'(11), 1'b0, COORD_MAX, COORD_MIN), 1'b1, error_seg());
        add_row(make_word(op_t'(15), 1'b1, '1, '1, '1, '1, '1, '1), 1'b1, error_seg());
        add_row(make_word(OP_M, 1'b0, COORD_MAX, COORD_MIN), 1'b1,
                point_seg(KIND_MOVE, COORD_MAX, COORD_MIN));
        // Relative move saturates on both axes.
        add_row(make_word(OP_M, 1'b1, coord_t'(1), '1), 1'b1,
                point_seg(KIND_MOVE, COORD_MAX, COORD_MIN));
        // Bare operands after a move continue as relative line.
        add_row(make_word(OP_NONE, 1'b0, '1, coord_t'(1)));
        add_row(make_word(OP_L, 1'b0, '0, '0), 1'b1, point_seg(KIND_LINE, '0, '0));
        add_row(make_word(OP_H, 1'b1, COORD_MIN, '1), 1'b1,
                point_seg(KIND_LINE, COORD_MIN, '0));
        add_row(make_word(OP_H, 1'b0, COORD_MAX, '1), 1'b1,
                point_seg(KIND_LINE, COORD_MAX, '0));
        add_row(make_word(OP_V, 1'b1, COORD_MAX, '0), 1'b1,
                point_seg(KIND_LINE, COORD_MAX, COORD_MAX));
        add_row(make_word(OP_V, 1'b0, '1, COORD_MAX));
        add_row(make_word(OP_C, 1'b0, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000,
                          32'h0004_0000, 32'h0005_0000, 32'h0006_0000));
        // Smooth cubics reflect after C and after S.
        add_row(make_word(OP_S, 1'b0, 32'h0007_0000, 32'h0008_0000,
                          32'h0009_0000, 32'h000A_0000));
        add_row(make_word(OP_S, 1'b1, 32'hFFFF_0000, 32'h0001_8000,
                          32'h0002_0000, 32'hFFFE_0000));
        add_row(make_word(OP_Q, 1'b0, COORD_MIN, COORD_MAX, 32'h0010_0000, '1));
        // Smooth quads reflect after Q and after T; reflection saturates here.
        add_row(make_word(OP_T, 1'b0, 32'h0020_0000, 32'h0030_0000));
        add_row(make_word(OP_T, 1'b1, 32'h0000_8000, 32'hFFFF_8000));
        // Smooth cubic after a quad does not reflect, nor a smooth quad after a cubic.
        add_row(make_word(OP_S, 1'b0, 32'h0100_0000, 32'h0200_0000,
                          32'h0300_0000, 32'h0400_0000));
        add_row(make_word(OP_T, 1'b0, 32'hFF00_0000, 32'h0080_0000));
        // Close returns to the subpath start; a repeat after it is an error.
        add_row(make_word(OP_Z, 1'b1, '1, '1));
        add_row(make_word(OP_NONE, 1'b1, 32'h10, 32'h20), 1'b1, error_seg());
        // Tilde ignores the relative flag and stays active for repeats.
        add_row(make_word(OP_TILDE, 1'b1, COORD_MIN, COORD_MAX, '1, '0));
        add_row(make_word(OP_NONE, 1'b0, 32'h0001_0000, '1, COORD_MAX, COORD_MIN));
        add_row(make_word(op_t'(12), 1'b0, '0, '0), 1'b1, error_seg());
        add_row(make_word(OP_M, 1'b0, '0, '0, '1, '1, '1, '1), 1'b1,
                point_seg(KIND_MOVE, '0, '0));

        // Reset: hold low, then release on an edge.
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (stim_table[i])
            send_word(stim_table[i].word, stim_table[i].pinned, stim_table[i].pin);

        // Let the directed part run dry before the random streams.
        drain_segments();

        after_close = 1'b0;
        for (int n = 0; n < RANDOM_WORDS; n++)
        begin
            // A quiet window with no idling on either side.
            calm = (n >= 700 && n < 1100);
            // Now and then hold off until the output side is empty.
            if (n > 0 && n % 500 == 0)
                drain_segments();

            pick = $urandom_range(0, 99);
            if (after_close && pick < 80)
                w.command = OP_M;
            else if (pick < 4)
                w.command = op_t'($urandom_range(11, 15));
            else if (pick < 20)
                w.command = OP_NONE;
            else if (pick < 28)
                w.command = OP_M;
            else if (pick < 34)
                w.command = OP_Z;
            else if (pick < 40)
                w.command = OP_TILDE;
            else
                w.command = op_t'($urandom_range(OP_L, OP_T));
            after_close = (w.command == OP_Z);

            w.is_relative = $urandom_range(0, 1);
            w.ax = pick_coord();
            w.ay = pick_coord();
            w.bx = pick_coord();
            w.by = pick_coord();
            w.cx = pick_coord();
            w.cy = pick_coord();
            send_word(w, 1'b0, '0);
        end
        calm = 1'b0;

        // Drain, then run an idle tail to show any stray word.
        drain_segments();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Covered %0d command words, %0d segment words checked", words_in, segs_checked);
        $display("including %0d error words, %0d closes and %0d tilde pairs",
                 error_segs, close_segs, tilde_pairs);
        if (mismatches == 0)
            $display("tb_svg_path_command_normalizer_top: clean");
        else
            $display("tb_svg_path_command_normalizer_top: errors");
        $finish;
    end

endmodule
